// ----- rtl/linear_blend_skinning_assert.svh -----
// Assertion macros shared by the skinning RTL.
// Needs clk and arst_n in scope where the macros are used.
`ifndef LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_ASSERT_SVH
`ifndef SYNTH
`define LBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define LBS_ASSERT_NOW(lbl, ante, cons, msg)
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/lbs_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and helpers for the linear blend skinning block.
// No dependencies.
package lbs_pkg;
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int WORD_W = 32;
	localparam int JOINT_W = 8;
	localparam int WGT_W = 16;
	localparam int N_INF = 4;
	localparam int N_ROW = 3;
	localparam int N_COL = 3;
	localparam int N_BANK = 12;
	localparam int BANK_W = 4;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = 2;
	localparam int Q_CNT_W = 3;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_SKIN = 1'b1
	} action_t;

	typedef struct packed {
		logic                              is_load;
		logic                              load_ok;
		logic [BANK_W-1:0]                 bank;
		logic [JOINT_W-1:0]                slot;
		logic [WORD_W-1:0]                 value;
		logic [N_COL-1:0][WORD_W-1:0]      pos;
		logic [N_COL-1:0][WORD_W-1:0]      norm;
		logic [N_INF-1:0][JOINT_W-1:0]     joint;
		logic [N_INF-1:0]                  jok;
		logic [N_INF-1:0][WGT_W-1:0]       wgt;
	} cmd_t;

	localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
	localparam logic signed [49:0] SAT_LO = -SAT_HI - 50'sd1;

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [49:0] x);
		logic signed [WORD_W-1:0] r;
		if (x > SAT_HI)
			r = 32'sh7fffffff;
		else if (x < SAT_LO)
			r = 32'sh80000000;
		else
			r = $signed(x[WORD_W-1:0]);
		return r;
	endfunction
endpackage

// ----- rtl/lbs_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: vertex/load beats in, skinned results out.
// No dependencies.
interface lbs_in_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic [7:0]         matrix_slot;
	logic [3:0]         matrix_element;
	logic signed [31:0] matrix_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] norm_x;
	logic signed [31:0] norm_y;
	logic signed [31:0] norm_z;
	logic [31:0]        joint_indices;
	logic [63:0]        blend_weights;

	modport source(output valid, action, matrix_slot, matrix_element, matrix_value,
		pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, joint_indices, blend_weights,
		input ready);
	modport sink(input valid, action, matrix_slot, matrix_element, matrix_value,
		pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, joint_indices, blend_weights,
		output ready);
endinterface

interface lbs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_pos_x;
	logic signed [31:0] out_pos_y;
	logic signed [31:0] out_pos_z;
	logic signed [31:0] out_norm_x;
	logic signed [31:0] out_norm_y;
	logic signed [31:0] out_norm_z;

	modport source(output valid, out_pos_x, out_pos_y, out_pos_z,
		out_norm_x, out_norm_y, out_norm_z, input ready);
	modport sink(input valid, out_pos_x, out_pos_y, out_pos_z,
		out_norm_x, out_norm_y, out_norm_z, output ready);
endinterface

// ----- rtl/lbs_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/lbs_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts beats, splits loads from vertices, unpacks joints/weights.
// Depends on lbs_pkg and lbs_if.
module lbs_front (
	lbs_in_if.sink        vtx,
	input  logic          q_ready,
	output logic          push,
	output lbs_pkg::cmd_t cmd
);
	import lbs_pkg::*;

	logic [1:0] col;
	logic [1:0] row;

	assign vtx.ready = q_ready;
	assign push = vtx.valid && q_ready;
	assign col = vtx.matrix_element[3:2];
	assign row = vtx.matrix_element[1:0];

	always_comb begin
		cmd = '0;
		cmd.is_load = (action_t'(vtx.action) == ACT_LOAD);
		// row 3 of a matrix never takes part in the transform
		cmd.load_ok = (row != 2'd3) && (int'(vtx.matrix_slot) < PALETTE_DEPTH);
		cmd.bank = BANK_W'(col) * BANK_W'(3) + BANK_W'(row);
		cmd.slot = vtx.matrix_slot;
		cmd.value = vtx.matrix_value;
		cmd.pos[0] = vtx.pos_x;
		cmd.pos[1] = vtx.pos_y;
		cmd.pos[2] = vtx.pos_z;
		cmd.norm[0] = vtx.norm_x;
		cmd.norm[1] = vtx.norm_y;
		cmd.norm[2] = vtx.norm_z;
		for (int i = 0; i < N_INF; i++) begin
			cmd.joint[i] = vtx.joint_indices[i*JOINT_W +: JOINT_W];
			cmd.jok[i] = int'(vtx.joint_indices[i*JOINT_W +: JOINT_W]) < PALETTE_DEPTH;
			cmd.wgt[i] = vtx.blend_weights[i*WGT_W +: WGT_W];
		end
	end
endmodule

// ----- rtl/lbs_fifo.sv -----
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on lbs_pkg.
`include "linear_blend_skinning_assert.svh"
module lbs_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lbs_pkg::cmd_t wdata,
	output logic          not_full,
	input  logic          pop,
	output logic          not_empty,
	output lbs_pkg::cmd_t rdata
);
	import lbs_pkg::*;

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_AW-1:0]    wr_ptr_q;
	logic [Q_AW-1:0]    rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign not_full = cnt_q != Q_CNT_W'(Q_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + Q_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - Q_CNT_W'(1);
		end
	end

	`LBS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= Q_CNT_W'(Q_DEPTH), "queue count over depth")
	`LBS_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + Q_CNT_W'(1), "queue count slip")
endmodule

// ----- rtl/lbs_back.sv -----
`timescale 1ns / 1ps
// Back end: palette banks, transform, weighting and output register.
// Depends on lbs_pkg, lbs_if and lbs_ram.
`include "linear_blend_skinning_assert.svh"
module lbs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  lbs_pkg::cmd_t q_cmd,
	input  logic          q_vld,
	output logic          q_pop,
	lbs_out_if.source     res
);
	import lbs_pkg::*;

	logic en;
	logic wr_go;
	logic res_vld_q;
	logic [WORD_W-1:0] ram_rd [N_INF][N_BANK];

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [WORD_W-1:0] pos_s1 [N_COL];
	logic signed [WORD_W-1:0] norm_s1 [N_COL];
	logic [N_INF-1:0] jok_s1;
	logic [WGT_W-1:0] wgt_s1 [N_INF];

	logic signed [47:0] pp_p_s2 [N_INF][N_ROW][N_COL];
	logic signed [47:0] pp_n_s2 [N_INF][N_ROW][N_COL];
	logic signed [WORD_W-1:0] tr_s2 [N_INF][N_ROW];
	logic [WGT_W-1:0] wgt_s2 [N_INF];

	logic signed [WORD_W-1:0] row_p_s3 [N_INF][N_ROW];
	logic signed [WORD_W-1:0] row_n_s3 [N_INF][N_ROW];
	logic [WGT_W-1:0] wgt_s3 [N_INF];

	logic signed [33:0] term_p_s4 [N_INF][N_ROW];
	logic signed [33:0] term_n_s4 [N_INF][N_ROW];

	logic signed [WORD_W-1:0] mat [N_INF][N_BANK];
	logic signed [WORD_W-1:0] out_p [N_ROW];
	logic signed [WORD_W-1:0] out_n [N_ROW];
	logic signed [WORD_W-1:0] out_p_q [N_ROW];
	logic signed [WORD_W-1:0] out_n_q [N_ROW];

	assign en = !res_vld_q || res.ready;
	assign q_pop = en && q_vld;
	assign wr_go = q_pop && q_cmd.is_load && q_cmd.load_ok;

	// one copy of each used matrix element per influence
	for (genvar i = 0; i < N_INF; i++) begin : g_inf
		for (genvar b = 0; b < N_BANK; b++) begin : g_bank
			lbs_ram #(.WIDTH(WORD_W), .DEPTH(PALETTE_DEPTH)) u_ram (
				.clk   (clk),
				.we    (wr_go && (q_cmd.bank == BANK_W'(b))),
				.waddr (q_cmd.slot[PAL_AW-1:0]),
				.wdata (q_cmd.value),
				.re    (en),
				.raddr (q_cmd.joint[i][PAL_AW-1:0]),
				.rdata (ram_rd[i][b])
			);
		end
	end

	always_comb begin
		for (int i = 0; i < N_INF; i++)
			for (int b = 0; b < N_BANK; b++)
				mat[i][b] = jok_s1[i] ? $signed(ram_rd[i][b]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= q_pop && !q_cmd.is_load;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			res_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < N_COL; c++) begin
				pos_s1[c] <= $signed(q_cmd.pos[c]);
				norm_s1[c] <= $signed(q_cmd.norm[c]);
			end
			jok_s1 <= q_cmd.jok;
			for (int i = 0; i < N_INF; i++) begin
				wgt_s1[i] <= q_cmd.wgt[i];
				wgt_s2[i] <= wgt_s1[i];
				wgt_s3[i] <= wgt_s2[i];
			end
		end
	end

	// s1 -> s2: matrix times vector products, floor by 2^16
	always_ff @(posedge clk) begin
		logic signed [63:0] pp, pn;
		if (en) begin
			for (int i = 0; i < N_INF; i++)
				for (int r = 0; r < N_ROW; r++) begin
					for (int c = 0; c < N_COL; c++) begin
						pp = mat[i][c*N_ROW + r] * pos_s1[c];
						pn = mat[i][c*N_ROW + r] * norm_s1[c];
						pp_p_s2[i][r][c] <= pp[63:16];
						pp_n_s2[i][r][c] <= pn[63:16];
					end
					tr_s2[i][r] <= mat[i][N_COL*N_ROW + r];
				end
		end
	end

	// s2 -> s3: row sums, saturated
	always_ff @(posedge clk) begin
		logic signed [49:0] sp, sn;
		if (en) begin
			for (int i = 0; i < N_INF; i++)
				for (int r = 0; r < N_ROW; r++) begin
					sp = 50'(pp_p_s2[i][r][0]) + 50'(pp_p_s2[i][r][1])
						+ 50'(pp_p_s2[i][r][2]) + 50'(tr_s2[i][r]);
					sn = 50'(pp_n_s2[i][r][0]) + 50'(pp_n_s2[i][r][1])
						+ 50'(pp_n_s2[i][r][2]);
					row_p_s3[i][r] <= sat_word(sp);
					row_n_s3[i][r] <= sat_word(sn);
				end
		end
	end

	// s3 -> s4: weighting, floor by 2^15
	always_ff @(posedge clk) begin
		logic signed [16:0] w;
		logic signed [48:0] wp, wn;
		if (en) begin
			for (int i = 0; i < N_INF; i++) begin
				w = $signed({1'b0, wgt_s3[i]});
				for (int r = 0; r < N_ROW; r++) begin
					wp = row_p_s3[i][r] * w;
					wn = row_n_s3[i][r] * w;
					term_p_s4[i][r] <= wp[48:15];
					term_n_s4[i][r] <= wn[48:15];
				end
			end
		end
	end

	always_comb begin
		logic signed [35:0] ap, an;
		for (int r = 0; r < N_ROW; r++) begin
			ap = '0;
			an = '0;
			for (int i = 0; i < N_INF; i++) begin
				ap = ap + 36'(term_p_s4[i][r]);
				an = an + 36'(term_n_s4[i][r]);
			end
			out_p[r] = sat_word(50'(ap));
			out_n[r] = sat_word(50'(an));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < N_ROW; r++) begin
				out_p_q[r] <= out_p[r];
				out_n_q[r] <= out_n[r];
			end
		end
	end

	assign res.valid = res_vld_q;
	assign res.out_pos_x = out_p_q[0];
	assign res.out_pos_y = out_p_q[1];
	assign res.out_pos_z = out_p_q[2];
	assign res.out_norm_x = out_n_q[0];
	assign res.out_norm_y = out_n_q[1];
	assign res.out_norm_z = out_n_q[2];

	`LBS_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_s2) && $stable(vld_s4), "pipe moved in stall")
	`LBS_ASSERT_NEXT(a_drain_out, en && vld_s4, res_vld_q, "result lost at output")
endmodule

// ----- rtl/linear_blend_skinning.sv -----
`timescale 1ns / 1ps
// Top level of the linear blend skinning block: front end, queue, back end.
// Depends on lbs_pkg, lbs_if, lbs_front, lbs_fifo, lbs_back.
//
//   port  dir  beat
//   vtx   in   palette word load or vertex (position, normal, joints, weights)
//   res   out  skinned position and normal, one per vertex
//
// One beat per cycle while res is not stalled; a vertex result passes through the queue,
// s1-s4 and the output register. Loads write the 48 palette banks when they leave the queue.
// Reset clears handshake and pipeline state only; the palette is not cleared.
// A stalled res freezes the back end; the four-entry queue keeps vtx open until it fills.
module linear_blend_skinning (
	input  logic      clk,
	input  logic      arst_n,
	lbs_in_if.sink    vtx,
	lbs_out_if.source res
);
	import lbs_pkg::*;

	cmd_t f_cmd;
	cmd_t q_cmd;
	logic push;
	logic q_ready;
	logic q_vld;
	logic q_pop;

	lbs_front u_front (
		.vtx     (vtx),
		.q_ready (q_ready),
		.push    (push),
		.cmd     (f_cmd)
	);

	lbs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (f_cmd),
		.not_full  (q_ready),
		.pop       (q_pop),
		.not_empty (q_vld),
		.rdata     (q_cmd)
	);

	lbs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_cmd  (q_cmd),
		.q_vld  (q_vld),
		.q_pop  (q_pop),
		.res    (res)
	);
endmodule
